[sv/lpht_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and sizes for the linear-probing hash table.
// No dependencies; imported by every module of the block but lpht_ram.
package lpht_pkg;

  // Table geometry: slot count is a power of two, home slot is the low key bits
  localparam int SLOT_BITS  = 8;
  localparam int SLOTS      = 1 << SLOT_BITS;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int ENTRY_BITS = 9;
  localparam int TAG_BITS   = 2;

  // Operation codes
  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_LOOKUP = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  // Slot tag codes
  localparam logic [TAG_BITS-1:0] TAG_EMPTY   = 2'd0;
  localparam logic [TAG_BITS-1:0] TAG_USED    = 2'd1;
  localparam logic [TAG_BITS-1:0] TAG_DELETED = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] key;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [8:0]  entries;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic advance;
    logic finish;
  } dp_cmd_t;

  // Datapath to controller: what the probed slot holds and if it is the last one
  typedef struct packed {
    logic hit;
    logic empty;
    logic last;
  } dp_stat_t;

endpackage

[sv/lpht_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module lpht_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[sv/lpht_ctrl.sv]
`timescale 1ns / 1ps
// Controller for the hash table: accepts items, steps the probe, owns out_valid.
// Depends on lpht_pkg.
module lpht_ctrl import lpht_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_PROBE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   stop;
  logic   out_free;

  assign in_stall = (state_r != S_IDLE);
  assign stop     = stat.hit | stat.empty | stat.last;
  assign out_free = ~out_valid_r | ~out_stall;

  // Decode commands and next state
  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        if (!stop) begin
          cmd.advance = 1'b1;
        end else if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Hold state and the result valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[sv/lpht_dp.sv]
`timescale 1ns / 1ps
// Datapath for the hash table: slot memories, probe index, result and count.
// Depends on lpht_pkg and lpht_ram.
module lpht_dp import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output out_item_t out_data
);

  // Request registers
  logic [1:0]            func_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;

  // Probe registers
  logic [SLOT_BITS-1:0]  idx_r, idx_nxt;
  logic [SLOT_BITS-1:0]  step_r, step_nxt;
  logic [SLOT_BITS-1:0]  free_r, free_nxt;
  logic                  free_seen_r, free_seen_nxt;

  // Table state outside the memories
  logic [SLOTS-1:0]      slot_vld_r, slot_vld_nxt;
  logic                  vld_q_r;
  logic [ENTRY_BITS-1:0] count_r, count_nxt;
  out_item_t             result_r, result_nxt;

  // Memory ports
  logic [SLOT_BITS-1:0]  rd_addr;
  logic [SLOT_BITS-1:0]  wr_addr;
  logic                  key_we, value_we, tag_we;
  logic [TAG_BITS-1:0]   tag_wdata;
  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] value_q;
  logic [TAG_BITS-1:0]   tag_q;
  logic [TAG_BITS-1:0]   tag_cur;
  logic                  cur_hit, cur_empty, cur_reuse;
  logic [KEY_BITS-1:0]   in_key;

  assign in_key = in_data.key[KEY_BITS-1:0];

  // Read the slot that the probe visits next
  always_comb begin
    if (cmd.load) begin
      rd_addr = in_key[SLOT_BITS-1:0];
    end else if (cmd.advance) begin
      rd_addr = idx_r + SLOT_BITS'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  lpht_ram #(.WIDTH(KEY_BITS), .DEPTH(SLOTS)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (wr_addr),
    .wdata (key_r),
    .raddr (rd_addr),
    .rdata (key_q)
  );

  lpht_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_value_ram (
    .clk   (clk),
    .we    (value_we),
    .waddr (wr_addr),
    .wdata (value_r),
    .raddr (rd_addr),
    .rdata (value_q)
  );

  lpht_ram #(.WIDTH(TAG_BITS), .DEPTH(SLOTS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (wr_addr),
    .wdata (tag_wdata),
    .raddr (rd_addr),
    .rdata (tag_q)
  );

  // A slot never written reads as empty
  assign tag_cur   = vld_q_r ? tag_q : TAG_EMPTY;
  assign cur_empty = (tag_cur == TAG_EMPTY);
  assign cur_hit   = (tag_cur == TAG_USED) && (key_q == key_r);
  assign cur_reuse = !cur_empty && (tag_cur != TAG_USED);

  assign stat.hit   = cur_hit;
  assign stat.empty = cur_empty;
  assign stat.last  = (step_r == SLOT_BITS'(SLOTS - 1));

  // Probe bookkeeping and request outcome
  always_comb begin
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    free_nxt      = free_r;
    free_seen_nxt = free_seen_r;
    slot_vld_nxt  = slot_vld_r;
    count_nxt     = count_r;
    result_nxt    = result_r;
    wr_addr       = idx_r;
    key_we        = 1'b0;
    value_we      = 1'b0;
    tag_we        = 1'b0;
    tag_wdata     = TAG_USED;

    if (cmd.load) begin
      idx_nxt       = in_key[SLOT_BITS-1:0];
      step_nxt      = '0;
      free_seen_nxt = 1'b0;
    end

    // Remember the first deleted slot on the path
    if (cmd.advance) begin
      idx_nxt  = idx_r + SLOT_BITS'(1);
      step_nxt = step_r + SLOT_BITS'(1);
      if (cur_reuse && !free_seen_r) begin
        free_seen_nxt = 1'b1;
        free_nxt      = idx_r;
      end
    end

    if (cmd.finish) begin
      result_nxt.status      = ST_NOT_FOUND;
      result_nxt.found_value = '0;
      case (func_r)
        FUNC_INSERT: begin
          if (cur_hit) begin
            value_we               = 1'b1;
            result_nxt.status      = ST_UPDATED;
            result_nxt.found_value = 32'(value_r);
          end else if (free_seen_r || cur_empty || cur_reuse) begin
            wr_addr           = free_seen_r ? free_r : idx_r;
            key_we            = 1'b1;
            value_we          = 1'b1;
            tag_we            = 1'b1;
            tag_wdata         = TAG_USED;
            slot_vld_nxt[wr_addr] = 1'b1;
            count_nxt         = count_r + ENTRY_BITS'(1);
            result_nxt.status = ST_INSERTED;
          end else begin
            result_nxt.status = ST_FULL;
          end
        end
        FUNC_LOOKUP: begin
          if (cur_hit) begin
            result_nxt.status      = ST_FOUND;
            result_nxt.found_value = 32'(value_q);
          end
        end
        FUNC_REMOVE: begin
          if (cur_hit) begin
            tag_we            = 1'b1;
            tag_wdata         = TAG_DELETED;
            result_nxt.status = ST_REMOVED;
            if (count_r != '0) begin
              count_nxt = count_r - ENTRY_BITS'(1);
            end
          end
        end
        default: begin
          result_nxt.status = ST_NOT_FOUND;
        end
      endcase
      result_nxt.entries = count_nxt;
    end
  end

  // Control state: valid bits, count, free-slot flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r  <= '0;
      count_r     <= '0;
      free_seen_r <= 1'b0;
      vld_q_r     <= 1'b0;
    end else begin
      slot_vld_r  <= slot_vld_nxt;
      count_r     <= count_nxt;
      free_seen_r <= free_seen_nxt;
      vld_q_r     <= slot_vld_r[rd_addr];
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_data.func;
      key_r   <= in_key;
      value_r <= in_data.value[VALUE_BITS-1:0];
    end
    idx_r    <= idx_nxt;
    step_r   <= step_nxt;
    free_r   <= free_nxt;
    result_r <= result_nxt;
  end

  assign out_data = result_r;

endmodule

[sv/linear_probe_hash_table.sv]
`timescale 1ns / 1ps
// Linear-probing key/value table: one request (insert/update, lookup, remove)
// per item, one result per item, SLOTS slots with deleted marks on removal.
// A request starts at slot key mod SLOTS and reads one slot per cycle through
// the key, value and tag memories until it finds the key, meets an empty slot
// or has visited every slot, so it probes 1 to SLOTS slots. No new item is
// taken while a request is still probing, and the one read port of the slot
// memories sets the probe pace. The result sits in an output register, and a
// new item is taken as soon as the previous one has finished probing, even
// while its result is still stalled. That next item then holds in its last
// probe cycle until the result register frees up. Slot tags reset to empty
// through per-slot valid flags, so there is no clearing pass after reset.
module linear_probe_hash_table import lpht_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for linear_probe_hash_table: an internal table
// predicts status, value and entry count for every request. Needs lpht_pkg.
module tb;
  import lpht_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int POOL_KEYS = 24;
  localparam int RANDOM_ITEMS = 210;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // Shadow copy of the table
  logic [KEY_BITS-1:0]   tbl_key [SLOTS];
  logic [VALUE_BITS-1:0] tbl_val [SLOTS];
  logic [TAG_BITS-1:0]   tbl_tag [SLOTS];
  int                    tbl_count;

  in_item_t  request_queue [$];
  out_item_t awaited_responses [$];

  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  squeeze = 1'b0;
  logic long_hold = 1'b0;
  int  mismatches = 0;
  int  cycle_count = 0;

  linear_probe_hash_table DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Apply one request to the shadow table and return the response it gives
  function automatic out_item_t table_response(in_item_t req);
    out_item_t res;
    int        idx;
    int        free_idx;
    int        hit_idx;
    bit        hit;
    bit        has_free;
    bit        done;
    res = '0;
    res.status = ST_NOT_FOUND;
    free_idx = 0;
    hit_idx = 0;
    hit = 1'b0;
    has_free = 1'b0;
    done = 1'b0;
    // Walk from the home slot: stop on the key, on an empty slot, or after a full round
    for (int i = 0; i < SLOTS && !done; i++) begin
      idx = (int'(req.key[SLOT_BITS-1:0]) + i) % SLOTS;
      if (tbl_tag[idx] == TAG_EMPTY) begin
        if (!has_free) begin
          has_free = 1'b1;
          free_idx = idx;
        end
        done = 1'b1;
      end else if (tbl_tag[idx] == TAG_USED) begin
        if (tbl_key[idx] == req.key) begin
          hit = 1'b1;
          hit_idx = idx;
          done = 1'b1;
        end
      end else if (!has_free) begin
        // deleted slot: first one on the path is the reuse candidate
        has_free = 1'b1;
        free_idx = idx;
      end
    end
    case (req.func)
      FUNC_INSERT: begin
        if (hit) begin
          tbl_val[hit_idx] = req.value;
          res.status = ST_UPDATED;
          res.found_value = req.value;
        end else if (has_free) begin
          tbl_key[free_idx] = req.key;
          tbl_val[free_idx] = req.value;
          tbl_tag[free_idx] = TAG_USED;
          tbl_count++;
          res.status = ST_INSERTED;
        end else begin
          res.status = ST_FULL;
        end
      end
      FUNC_LOOKUP: begin
        if (hit) begin
          res.status = ST_FOUND;
          res.found_value = tbl_val[hit_idx];
        end
      end
      FUNC_REMOVE: begin
        if (hit) begin
          tbl_tag[hit_idx] = TAG_DELETED;
          if (tbl_count > 0) tbl_count--;
          res.status = ST_REMOVED;
        end
      end
      default: ;
    endcase
    res.entries = tbl_count[ENTRY_BITS-1:0];
    return res;
  endfunction

  task automatic flag_error(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s at cycle %0d: expected 0x%0h, actual 0x%0h",
               what, cycle_count, want, got);
  endtask

  task automatic push_req(input logic [1:0] func, input logic [31:0] key,
                          input logic [31:0] value);
    in_item_t req;
    req.func = func;
    req.key = key;
    req.value = value;
    request_queue.push_back(req);
  endtask

  // Wait until every item is taken and every response has come back
  task automatic drain();
    while (request_queue.size() != 0 || in_valid || awaited_responses.size() != 0)
      @(negedge clk);
  endtask

  // Request driver: predict on acceptance, hold a stalled item, idle at random
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) awaited_responses.push_back(table_response(in_data));
      if (!in_valid || !in_stall) begin
        if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compare against the oldest prediction, stall at random
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_responses.size() == 0) begin
          flag_error("unrequested response status", '0, 32'(out_data.status));
        end else begin
          want = awaited_responses.pop_front();
          if (out_data.status !== want.status)
            flag_error("status", 32'(want.status), 32'(out_data.status));
          if (out_data.found_value !== want.found_value)
            flag_error("found_value", want.found_value, out_data.found_value);
          if (out_data.entries !== want.entries)
            flag_error("entries", 32'(want.entries), 32'(out_data.entries));
        end
      end
      out_stall <= long_hold || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Hold off the response side long enough for the block to back up
  initial begin : long_hold_off
    wait (squeeze);
    repeat (30) @(posedge clk);
    long_hold <= 1'b1;
    repeat (150) @(posedge clk);
    long_hold <= 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : stimulus
    logic [31:0] key_pool [$];
    logic [31:0] fresh_keys [$];
    logic [1:0]  func;
    logic [31:0] key;
    int          pick;
    int          base;
    int          fill_count;
    int          send_pct [4];
    int          recv_pct [4];
    send_pct = '{0, 73, 0, 35};
    recv_pct = '{0, 0, 73, 35};
    foreach (tbl_tag[i]) tbl_tag[i] = TAG_EMPTY;
    tbl_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty table, extremes, wrap-around, deleted marks, unused code
    push_req(FUNC_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(FUNC_REMOVE, 32'h0000_0000, 32'h0000_0000);
    push_req(FUNC_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
    push_req(FUNC_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(FUNC_INSERT, 32'h0000_01FF, 32'h1234_5678);
    push_req(FUNC_LOOKUP, 32'h0000_01FF, 32'h0000_0000);
    push_req(FUNC_INSERT, 32'h0000_01FF, 32'hA5A5_A5A5);
    push_req(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(FUNC_REMOVE, 32'h0000_0000, 32'hFFFF_FFFF);
    push_req(FUNC_LOOKUP, 32'h0000_01FF, 32'h0000_0000);
    push_req(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    push_req(FUNC_INSERT, 32'h0000_0100, 32'h5A5A_5A5A);
    push_req(FUNC_LOOKUP, 32'h0000_0100, 32'h0000_0000);
    push_req(FUNC_UNUSED, 32'h0000_0100, 32'h0000_0000);
    push_req(FUNC_LOOKUP, 32'h0000_0100, 32'h0000_0000);
    push_req(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(FUNC_REMOVE, 32'hFFFF_FFFF, 32'h0000_0000);
    push_req(FUNC_INSERT, 32'h0000_02FF, 32'h0000_0001);
    push_req(FUNC_REMOVE, 32'h0000_01FF, 32'h0000_0000);
    push_req(FUNC_REMOVE, 32'h0000_02FF, 32'h0000_0000);
    push_req(FUNC_REMOVE, 32'h0000_0100, 32'h0000_0000);
    push_req(FUNC_LOOKUP, 32'h0000_03FF, 32'h0000_0000);
    drain();

    // Random: clustered keys so probe chains collide, wrap and cross deleted slots
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      if (phase == 0) squeeze = 1'b1;
      base = (phase == 0) ? 250 : $urandom_range(255);
      key_pool.delete();
      for (int i = 0; i < POOL_KEYS; i++)
        key_pool.push_back({24'($urandom_range(7)), 8'((base + $urandom_range(11)) % SLOTS)});
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
        pick = $urandom_range(99);
        if (pick < 45) func = FUNC_INSERT;
        else if (pick < 75) func = FUNC_LOOKUP;
        else if (pick < 95) func = FUNC_REMOVE;
        else func = FUNC_UNUSED;
        key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(key_pool.size() - 1)]
                                        : $urandom();
        push_req(func, key, $urandom());
      end
      drain();
    end

    // Fill the table, then work it while full
    fill_count = SLOTS - tbl_count + 3;
    for (int i = 0; i < fill_count; i++) begin
      key = $urandom();
      fresh_keys.push_back(key);
      push_req(FUNC_INSERT, key, $urandom());
    end
    push_req(FUNC_INSERT, fresh_keys[0], $urandom());
    push_req(FUNC_LOOKUP, $urandom(), $urandom());
    push_req(FUNC_LOOKUP, fresh_keys[1], 32'h0000_0000);
    push_req(FUNC_REMOVE, fresh_keys[2], 32'h0000_0000);
    push_req(FUNC_INSERT, $urandom(), $urandom());
    push_req(FUNC_INSERT, $urandom(), $urandom());
    push_req(FUNC_UNUSED, fresh_keys[3], $urandom());
    push_req(FUNC_REMOVE, $urandom(), 32'h0000_0000);
    push_req(FUNC_LOOKUP, fresh_keys[0], 32'h0000_0000);
    drain();

    // Let any stray response show up before the verdict
    repeat (SLOTS + 40) @(posedge clk);
    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
